/* hw/rtl/sst_pkg.sv */
// Shared types and constants for the sorted set table.
package sst_pkg;

  localparam int CAPACITY = 32;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CFG_W    = 6;
  localparam int RANK_W   = 5;
  localparam int OCNT_W   = 6;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_ERASE    = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_GET      = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_GET,
    ST_GET_Q,
    ST_INS_RD,
    ST_INS_WR,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [KEY_W-1:0]  key_out;
    logic [OCNT_W-1:0] count;
    logic              is_empty;
  } rsp_t;

endpackage

/* hw/rtl/sorted_set_table_core.sv */
// Sorted set table: distinct unsigned keys kept in ascending order in one memory.
// One request at a time. Keys live in a single-port-read, single-port-write memory
// with a registered read, so each visited entry takes a read state and then a compare
// state. A search walks up from rank 0 until it meets a key not below the request
// key or runs past the last key; p is the key's sorted position. Insert then moves
// each entry at or above p up by one, erase moves the entries above p down by one.
// Get reads the entry at the request rank if it is below the count. A request waits
// to finish while the response register stays stalled. The response lands in an
// output register, and a new request is taken while an earlier response still waits
// there. max_entries above the store depth acts as the store depth; lowering it below
// the count drops nothing.
module sorted_set_table_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  sst_pkg::req_t                    req,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output sst_pkg::rsp_t                    rsp,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sst_pkg::CFG_W-1:0]        cfg_data
);

  logic [sst_pkg::KEY_W-1:0] mem [sst_pkg::CAPACITY];
  logic [sst_pkg::KEY_W-1:0] mem_q;

  sst_pkg::state_t              state, state_next;
  sst_pkg::cmd_t                op;
  logic [sst_pkg::KEY_W-1:0]    key;
  logic [sst_pkg::RANK_W-1:0]   rank;
  logic [sst_pkg::CNT_W-1:0]    count;
  logic [sst_pkg::CNT_W-1:0]    pos;
  logic [sst_pkg::CNT_W-1:0]    idx;
  logic [sst_pkg::CFG_W-1:0]    max_entries;
  logic                         res_ok;
  logic [sst_pkg::KEY_W-1:0]    res_key;

  logic                         rd_en;
  logic [sst_pkg::IDX_W-1:0]    rd_addr;
  logic                         wr_en;
  logic [sst_pkg::IDX_W-1:0]    wr_addr;
  logic [sst_pkg::KEY_W-1:0]    wr_data;

  logic [sst_pkg::CNT_W-1:0]    limit;
  logic                         srch_end;
  logic                         found;
  logic                         rank_ok;
  logic                         del_more;
  logic                         rsp_free;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != sst_pkg::ST_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign limit = (32'(max_entries) > 32'(sst_pkg::CAPACITY)) ?
                 sst_pkg::CNT_W'(sst_pkg::CAPACITY) : sst_pkg::CNT_W'(max_entries);

  // The search ends on an empty tail or on the first key not below the request key.
  assign srch_end = ((state == sst_pkg::ST_SEARCH) && (pos >= count)) ||
                    ((state == sst_pkg::ST_CMP) && !(mem_q < key));
  assign found    = (state == sst_pkg::ST_CMP) && (mem_q == key);
  assign rank_ok  = 32'(rank) < 32'(count);
  assign del_more = ({1'b0, idx} + 1'b1) < {1'b0, count};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sst_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = (sst_pkg::cmd_t'(req.command) == sst_pkg::CMD_GET) ?
                       sst_pkg::ST_GET : sst_pkg::ST_SEARCH;
        end
      end
      sst_pkg::ST_SEARCH, sst_pkg::ST_CMP: begin
        if (srch_end) begin
          case (op)
            sst_pkg::CMD_INSERT:
              state_next = (!found && count < limit) ? sst_pkg::ST_INS_RD : sst_pkg::ST_DONE;
            sst_pkg::CMD_ERASE:
              state_next = found ? sst_pkg::ST_DEL_RD : sst_pkg::ST_DONE;
            default:
              state_next = sst_pkg::ST_DONE;
          endcase
        end else if (state == sst_pkg::ST_SEARCH) begin
          state_next = sst_pkg::ST_CMP;
        end else begin
          state_next = sst_pkg::ST_SEARCH;
        end
      end
      sst_pkg::ST_GET:    state_next = rank_ok ? sst_pkg::ST_GET_Q : sst_pkg::ST_DONE;
      sst_pkg::ST_GET_Q:  state_next = sst_pkg::ST_DONE;
      sst_pkg::ST_INS_RD: state_next = (idx > pos) ? sst_pkg::ST_INS_WR : sst_pkg::ST_DONE;
      sst_pkg::ST_INS_WR: state_next = sst_pkg::ST_INS_RD;
      sst_pkg::ST_DEL_RD: state_next = del_more ? sst_pkg::ST_DEL_WR : sst_pkg::ST_DONE;
      sst_pkg::ST_DEL_WR: state_next = sst_pkg::ST_DEL_RD;
      sst_pkg::ST_DONE:   state_next = rsp_free ? sst_pkg::ST_IDLE : sst_pkg::ST_DONE;
      default:            state_next = sst_pkg::ST_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos[sst_pkg::IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = idx[sst_pkg::IDX_W-1:0];
    wr_data = mem_q;
    case (state)
      sst_pkg::ST_SEARCH: begin
        rd_en = (pos < count);
      end
      sst_pkg::ST_GET: begin
        rd_en   = rank_ok;
        rd_addr = sst_pkg::IDX_W'(rank);
      end
      sst_pkg::ST_INS_RD: begin
        if (idx > pos) begin
          rd_en   = 1'b1;
          rd_addr = sst_pkg::IDX_W'(idx - 1'b1);
        end else begin
          wr_en   = 1'b1;
          wr_addr = pos[sst_pkg::IDX_W-1:0];
          wr_data = key;
        end
      end
      sst_pkg::ST_INS_WR: begin
        wr_en = 1'b1;
      end
      sst_pkg::ST_DEL_RD: begin
        rd_en   = del_more;
        rd_addr = sst_pkg::IDX_W'(idx + 1'b1);
      end
      sst_pkg::ST_DEL_WR: begin
        wr_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sst_pkg::ST_IDLE;
      count       <= '0;
      max_entries <= sst_pkg::CFG_W'(sst_pkg::CAPACITY);
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        max_entries <= cfg_data;
      end
      if (state == sst_pkg::ST_INS_RD && !(idx > pos)) begin
        count <= count + 1'b1;
      end
      if (state == sst_pkg::ST_DEL_RD && !del_more) begin
        count <= count - 1'b1;
      end
      if (state == sst_pkg::ST_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request latch, walk pointers and response staging.
  always_ff @(posedge clk) begin
    case (state)
      sst_pkg::ST_IDLE: begin
        op      <= sst_pkg::cmd_t'(req.command);
        key     <= req.key;
        rank    <= req.rank;
        pos     <= '0;
        res_ok  <= 1'b0;
        res_key <= '0;
      end
      sst_pkg::ST_SEARCH, sst_pkg::ST_CMP: begin
        if (srch_end) begin
          res_ok <= (op == sst_pkg::CMD_CONTAINS) && found;
          idx    <= (op == sst_pkg::CMD_INSERT) ? count : pos;
        end else if (state == sst_pkg::ST_CMP) begin
          pos <= pos + 1'b1;
        end
      end
      sst_pkg::ST_GET_Q: begin
        res_ok  <= 1'b1;
        res_key <= mem_q;
      end
      sst_pkg::ST_INS_RD: begin
        if (!(idx > pos)) begin
          res_ok <= 1'b1;
        end
      end
      sst_pkg::ST_INS_WR: begin
        idx <= idx - 1'b1;
      end
      sst_pkg::ST_DEL_RD: begin
        if (!del_more) begin
          res_ok <= 1'b1;
        end
      end
      sst_pkg::ST_DEL_WR: begin
        idx <= idx + 1'b1;
      end
      default: begin
        res_ok <= res_ok;
      end
    endcase
    if (state == sst_pkg::ST_DONE && rsp_free) begin
      rsp.ok       <= res_ok;
      rsp.key_out  <= res_key;
      rsp.count    <= sst_pkg::OCNT_W'(count);
      rsp.is_empty <= (count == '0);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(sst_pkg::CAPACITY))
    else $error("entry count above store depth");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == sst_pkg::ST_IDLE || state == sst_pkg::ST_DONE) |-> !wr_en)
    else $error("memory write outside a shift or insert");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write to the same entry in one cycle");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(count)) |->
      ($past(state) == sst_pkg::ST_INS_RD || $past(state) == sst_pkg::ST_DEL_RD))
    else $error("entry count changed outside insert or erase completion");
`endif

endmodule

/* tb/sv/sorted_set_table_check.sv */
// Checker for the sorted set table: mirrors the key store and compares every response.
module sorted_set_table_check
  import sst_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_stall,
  input  req_t             req,
  input  logic             rsp_valid,
  input  logic             rsp_stall,
  input  rsp_t             rsp,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output int unsigned      mismatches,
  output int unsigned      outstanding
);

  logic [KEY_W-1:0] held_keys [CAPACITY];
  int unsigned      held_count;
  logic [CFG_W-1:0] limit_reg;
  rsp_t             want_rsps [$];

  // Apply one request to the mirrored set and return the response it must produce.
  task automatic apply_to_set(input req_t r, output rsp_t o);
    int unsigned pos;
    int unsigned lim;
    int unsigned i;
    bit          hit;
    pos = 0;
    while (pos < held_count && held_keys[pos] < r.key) pos++;
    hit = (pos < held_count) && (held_keys[pos] == r.key);
    lim = (limit_reg > CAPACITY) ? CAPACITY : limit_reg;
    o = '0;
    case (r.command)
      CMD_INSERT: begin
        if (!hit && held_count < lim) begin
          for (i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
          held_keys[pos] = r.key;
          held_count++;
          o.ok = 1'b1;
        end
      end
      CMD_ERASE: begin
        if (hit) begin
          for (i = pos; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
          held_count--;
          o.ok = 1'b1;
        end
      end
      CMD_CONTAINS: begin
        o.ok = hit;
      end
      default: begin
        if (r.rank < held_count) begin
          o.key_out = held_keys[r.rank];
          o.ok = 1'b1;
        end
      end
    endcase
    o.count    = held_count[OCNT_W-1:0];
    o.is_empty = (held_count == 0);
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    rsp_t next_rsp;
    if (rst) begin
      held_count = 0;
      limit_reg  = CFG_W'(32);
      want_rsps.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) limit_reg = cfg_data;
      if (rsp_valid && !rsp_stall) begin
        if (want_rsps.size() == 0) begin
          $display("%0t: response with none pending: ok %0b key_out %h count %0d empty %0b",
                   $time, rsp.ok, rsp.key_out, rsp.count, rsp.is_empty);
          mismatches <= mismatches + 1;
        end else begin
          want = want_rsps.pop_front();
          if (rsp.ok !== want.ok || rsp.key_out !== want.key_out ||
              rsp.count !== want.count || rsp.is_empty !== want.is_empty) begin
            if (rsp.ok !== want.ok)
              $display("%0t: ok expected %0b got %0b", $time, want.ok, rsp.ok);
            if (rsp.key_out !== want.key_out)
              $display("%0t: key_out expected %h got %h", $time, want.key_out, rsp.key_out);
            if (rsp.count !== want.count)
              $display("%0t: count expected %0d got %0d", $time, want.count, rsp.count);
            if (rsp.is_empty !== want.is_empty)
              $display("%0t: is_empty expected %0b got %0b", $time, want.is_empty,
                       rsp.is_empty);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (req_valid && !req_stall) begin
        apply_to_set(req, next_rsp);
        want_rsps.push_back(next_rsp);
      end
      outstanding <= want_rsps.size();
    end
  end

endmodule

/* tb/sv/sorted_set_table_core_tb.sv */
// Top of the sorted set table testbench: clock, reset, requests, stalls and verdict.
module sorted_set_table_core_tb;
  import sst_pkg::*;

  localparam int POOL = 40;
  localparam int HOLD_CYCLES = 400;

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_stall;
  rsp_t             rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  int unsigned      mismatches;
  int unsigned      outstanding;
  int unsigned      sender_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      hold_asks;
  logic [KEY_W-1:0] key_pool [POOL];

  sorted_set_table_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  sorted_set_table_check checker_i (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin : limit
    #20000000;
    $display("sorted_set_table_core_tb NOT OK");
    $finish;
  end

  // Response side: random stall, or a long hold-off when the stimulus asks for one.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    rsp_stall = 1'b0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic req_t mk(cmd_t c, logic [KEY_W-1:0] k, logic [RANK_W-1:0] r);
    req_t x;
    x.command = c;
    x.key     = k;
    x.rank    = r;
    return x;
  endfunction

  // Mostly keys from a small pool so that hits, duplicates and full stores are common.
  function automatic req_t random_request(int unsigned ins_pct, int unsigned era_pct);
    int unsigned pick;
    cmd_t        c;
    pick = $urandom_range(99);
    if (pick < ins_pct) c = CMD_INSERT;
    else if (pick < ins_pct + era_pct) c = CMD_ERASE;
    else if ($urandom_range(1) == 0) c = CMD_CONTAINS;
    else c = CMD_GET;
    return mk(c, ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL-1)] : $urandom,
              RANK_W'($urandom_range(31)));
  endfunction

  // Offer one request, with optional idle cycles, and hold it until taken.
  task automatic offer(input req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  // Drop valid and wait until every response is back.
  task automatic settle();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int unsigned n, int unsigned ins_pct, int unsigned era_pct);
    repeat (n) offer(random_request(ins_pct, era_pct));
    settle();
  endtask

  initial begin : stimulus
    int i;
    rst             = 1'b1;
    req_valid       = 1'b0;
    req             = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_asks       = 0;
    for (i = 0; i < POOL; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h0000_0001;
    key_pool[3] = 32'h8000_0000;
    key_pool[4] = 32'h7FFF_FFFF;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty store, boundary keys and ranks
    offer(mk(CMD_CONTAINS, 32'h0, 5'd0));
    offer(mk(CMD_GET,      32'h0, 5'd0));
    offer(mk(CMD_ERASE,    32'h5, 5'd0));
    offer(mk(CMD_INSERT,   32'hFFFF_FFFF, 5'd0));
    offer(mk(CMD_INSERT,   32'h0, 5'd31));
    offer(mk(CMD_INSERT,   32'h0, 5'd0));
    offer(mk(CMD_INSERT,   32'h8000_0000, 5'd0));
    offer(mk(CMD_INSERT,   32'h1, 5'd0));
    offer(mk(CMD_INSERT,   32'h7FFF_FFFF, 5'd0));
    offer(mk(CMD_GET,      32'hFFFF_FFFF, 5'd0));
    offer(mk(CMD_GET,      32'h0, 5'd4));
    offer(mk(CMD_GET,      32'h0, 5'd5));
    offer(mk(CMD_GET,      32'h0, 5'd31));
    offer(mk(CMD_CONTAINS, 32'hFFFF_FFFF, 5'd0));
    offer(mk(CMD_CONTAINS, 32'h2, 5'd0));
    offer(mk(CMD_ERASE,    32'h8000_0000, 5'd0));
    offer(mk(CMD_ERASE,    32'h8000_0000, 5'd0));
    offer(mk(CMD_ERASE,    32'hFFFF_FFFF, 5'd0));
    offer(mk(CMD_ERASE,    32'h0, 5'd0));
    offer(mk(CMD_ERASE,    32'h1, 5'd0));
    offer(mk(CMD_ERASE,    32'h7FFF_FFFF, 5'd0));
    settle();

    // tiny limit: fill it, then lower it below the count
    write_limit(CFG_W'(2));
    offer(mk(CMD_INSERT, 32'h10, 5'd0));
    offer(mk(CMD_INSERT, 32'h20, 5'd0));
    offer(mk(CMD_INSERT, 32'h30, 5'd0));
    settle();
    write_limit(CFG_W'(1));
    offer(mk(CMD_INSERT, 32'h40, 5'd0));
    offer(mk(CMD_ERASE,  32'h10, 5'd0));
    offer(mk(CMD_GET,    32'h0,  5'd0));
    settle();

    // limit above the store depth, fill the store completely
    write_limit(CFG_W'(63));
    run_phase(220, 65, 15);

    // limit below the count, sender idles
    sender_idle_pct = 51;
    write_limit(CFG_W'(5));
    run_phase(120, 40, 30);

    // zero limit, receiver stalls
    sender_idle_pct = 0;
    recv_stall_pct  = 51;
    write_limit(CFG_W'(0));
    run_phase(60, 50, 25);

    // full depth, both sides idle, with a long hold-off to back the block up
    sender_idle_pct = 21;
    recv_stall_pct  = 21;
    write_limit(CFG_W'(32));
    hold_asks <= hold_asks + 1;
    run_phase(200, 45, 35);

    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    write_limit(CFG_W'(17));
    run_phase(150, 30, 50);

    // drain: catch any stray response
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_set_table_core_tb OK");
    end else begin
      $display("sorted_set_table_core_tb NOT OK");
    end
    $finish;
  end

endmodule
